/* hw/rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg: shared definitions of the deadline timer table
// Field widths, operation and status codes, controller/datapath signal groups.
// ----------------------------------------------------------------------------
package dtt_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int MAX_RESULTS    = 16;

	localparam int OP_W     = 2;
	localparam int ID_W     = 32;
	localparam int TIME_W   = 48;
	localparam int LIM_W    = 5;
	localparam int STATUS_W = 2;
	localparam int ACNT_W   = 5;
	localparam int CNT_MAX_W = 7;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
	localparam logic [OP_W-1:0] OP_GET    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
		logic emit;
	} dtt_cmd_t;

	typedef struct packed {
		logic out_free;
		logic op_tick;
		logic fired_any;
		logic fire_at_idx;
		logic emit_last;
	} dtt_sts_t;

	function automatic int idx_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic logic [ACNT_W-1:0] sat_count(input logic [CNT_MAX_W-1:0] cnt);
		return (cnt > CNT_MAX_W'(31)) ? ACNT_W'(31) : cnt[ACNT_W-1:0];
	endfunction

endpackage

/* hw/rtl/dtt_in_if.sv */
// ----------------------------------------------------------------------------
// dtt_in_if: request channel of the deadline timer table
// One word carries an operation with its id, time and fire limit.
// ----------------------------------------------------------------------------
interface dtt_in_if import dtt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ID_W-1:0]   timer_key;
	logic [TIME_W-1:0] time_ms;
	logic [LIM_W-1:0]  fire_cap;

	modport source (output valid, opcode, timer_key, time_ms, fire_cap, input ready);
	modport sink   (input valid, opcode, timer_key, time_ms, fire_cap, output ready);
endinterface

/* hw/rtl/dtt_out_if.sv */
// ----------------------------------------------------------------------------
// dtt_out_if: result channel of the deadline timer table
// One word carries one result of an operation.
// ----------------------------------------------------------------------------
interface dtt_out_if import dtt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                id_valid;
	logic [ID_W-1:0]     result_id;
	logic [TIME_W-1:0]   fire_time;
	logic [ACNT_W-1:0]   active_count;
	logic                last;

	modport source (output valid, status, id_valid, result_id, fire_time, active_count, last,
		input ready);
	modport sink   (input valid, status, id_valid, result_id, fire_time, active_count, last,
		output ready);
endinterface

/* hw/rtl/deadline_timer_table_core.sv */
// ----------------------------------------------------------------------------
// deadline_timer_table_core: table of one-shot deadline timers
// Create, cancel, get and tick over NUM_TIMERS slots of id and fire time.
// ----------------------------------------------------------------------------
// One request word is taken at a time. Every operation walks all slots through
// the id/deadline RAM read port, one slot per cycle, and passes a drain state;
// create, cancel, get and a tick that fires nothing then commit one result word
// once the output register is free. A tick that fires timers instead walks the
// fire mask again over the same read port, slot by slot up to the last fired
// one, and emits one result word per fired timer. Results wait in an output
// register; a stalled result channel holds up the commit and each emit. Slot
// busy bits sit in flip-flops, so the table is usable right after reset.
module deadline_timer_table_core import dtt_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dtt_in_if.sink    req,
	dtt_out_if.source rsp
);
	dtt_cmd_t                     cmd;
	dtt_sts_t                     sts;
	logic [idx_w(NUM_TIMERS)-1:0] idx;

	dtt_ctrl #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx)
	);

	dtt_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.opcode    (req.opcode),
		.timer_key (req.timer_key),
		.time_ms   (req.time_ms),
		.fire_cap  (req.fire_cap),
		.sts       (sts),
		.rsp       (rsp)
	);
endmodule

/* hw/rtl/dtt_ram.sv */
// ----------------------------------------------------------------------------
// dtt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtt_ram import dtt_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [idx_w(DEPTH)-1:0]   wr_addr,
	input  logic [WIDTH-1:0]          wr_data,
	input  logic [idx_w(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]          rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

/* hw/rtl/dtt_dp.sv */
// ----------------------------------------------------------------------------
// dtt_dp: datapath of the deadline timer table
// Slot busy bits, id/deadline RAM, compare stage, fire mask and result register.
// ----------------------------------------------------------------------------
module dtt_dp import dtt_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtt_cmd_t                      cmd,
	input  logic [idx_w(NUM_TIMERS)-1:0]  idx,
	input  logic [OP_W-1:0]               opcode,
	input  logic [ID_W-1:0]               timer_key,
	input  logic [TIME_W-1:0]             time_ms,
	input  logic [LIM_W-1:0]              fire_cap,
	output dtt_sts_t                      sts,
	dtt_out_if.source                     rsp
);
	localparam int IDX_W = idx_w(NUM_TIMERS);
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int ENT_W = ID_W + TIME_W;

	logic [OP_W-1:0]       op_q;
	logic [ID_W-1:0]       id_q;
	logic [TIME_W-1:0]     time_q;
	logic [LIM_W-1:0]      lim_q;
	logic [NUM_TIMERS-1:0] busy_q;
	logic [NUM_TIMERS-1:0] fire_q;
	logic [CNT_W-1:0]      count_q;
	logic                  found_q;
	logic                  free_q;
	logic [IDX_W-1:0]      found_idx_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [TIME_W-1:0]     found_time_q;
	logic [RES_CNT_W-1:0]  k_q;
	logic [RES_CNT_W-1:0]  e_q;
	logic                  cmp_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  out_valid_q;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [ENT_W-1:0]      rd_data;
	logic [ID_W-1:0]       rd_ident;
	logic [TIME_W-1:0]     rd_time;
	logic                  op_tick;
	logic                  hit;
	logic                  expired;
	logic                  take_free;

	logic [STATUS_W-1:0]   s_status;
	logic                  s_valid;
	logic [ID_W-1:0]       s_id;
	logic [TIME_W-1:0]     s_time;
	logic [CNT_W-1:0]      s_count;

	dtt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_TIMERS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({id_q, time_q}),
		.rd_addr (idx),
		.rd_data (rd_data)
	);

	assign rd_ident  = rd_data[ENT_W-1:TIME_W];
	assign rd_time   = rd_data[TIME_W-1:0];
	assign op_tick   = (op_q == OP_TICK);
	assign hit       = cmp_s1 && busy_q[idx_s1] && (rd_ident == id_q) && !found_q;
	assign expired   = cmp_s1 && busy_q[idx_s1] && (rd_time <= time_q) && (k_q < lim_q);
	assign take_free = cmp_s1 && !busy_q[idx_s1] && !free_q;

	assign wr_en   = cmd.commit && (op_q == OP_CREATE) && (found_q || free_q);
	assign wr_addr = found_q ? found_idx_q : free_idx_q;

	always_comb begin
		s_status = ST_OK;
		s_valid  = 1'b0;
		s_id     = '0;
		s_time   = '0;
		s_count  = count_q;
		case (op_q)
			OP_CREATE: begin
				if (!found_q) begin
					if (free_q) begin
						s_count = count_q + CNT_W'(1);
					end else begin
						s_status = ST_FULL;
					end
				end
			end
			OP_CANCEL: begin
				if (found_q) begin
					s_count = count_q - CNT_W'(1);
				end else begin
					s_status = ST_NOT_FOUND;
				end
			end
			OP_GET: begin
				if (found_q) begin
					s_valid = 1'b1;
					s_id    = id_q;
					s_time  = found_time_q;
				end else begin
					s_status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			fire_q      <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			k_q         <= '0;
			e_q         <= '0;
			cmp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_s1 <= cmd.scan;
			if (cmd.load) begin
				found_q <= 1'b0;
				free_q  <= 1'b0;
				k_q     <= '0;
				e_q     <= '0;
				fire_q  <= '0;
			end
			if (cmp_s1) begin
				if (op_tick) begin
					if (expired) begin
						busy_q[idx_s1] <= 1'b0;
						fire_q[idx_s1] <= 1'b1;
						k_q            <= k_q + RES_CNT_W'(1);
						count_q        <= count_q - CNT_W'(1);
					end
				end else begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (take_free) begin
						free_q <= 1'b1;
					end
				end
			end
			if (cmd.commit) begin
				if ((op_q == OP_CREATE) && !found_q && free_q) begin
					busy_q[free_idx_q] <= 1'b1;
				end
				if ((op_q == OP_CANCEL) && found_q) begin
					busy_q[found_idx_q] <= 1'b0;
				end
				count_q <= s_count;
			end
			if (cmd.emit) begin
				e_q <= e_q + RES_CNT_W'(1);
			end
			if (cmd.commit || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		if (cmd.load) begin
			op_q   <= opcode;
			id_q   <= timer_key;
			time_q <= time_ms;
			lim_q  <= (fire_cap > LIM_W'(MAX_RESULTS)) ? LIM_W'(MAX_RESULTS) : fire_cap;
		end
		if (!op_tick && hit) begin
			found_idx_q  <= idx_s1;
			found_time_q <= rd_time;
		end
		if (!op_tick && take_free) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.commit) begin
			rsp.status       <= s_status;
			rsp.id_valid     <= s_valid;
			rsp.result_id    <= s_id;
			rsp.fire_time    <= s_time;
			rsp.active_count <= sat_count(CNT_MAX_W'(s_count));
			rsp.last         <= 1'b1;
		end else if (cmd.emit) begin
			rsp.status       <= ST_OK;
			rsp.id_valid     <= 1'b1;
			rsp.result_id    <= rd_ident;
			rsp.fire_time    <= '0;
			rsp.active_count <= sat_count(CNT_MAX_W'(count_q));
			rsp.last         <= sts.emit_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign sts.out_free    = !out_valid_q || rsp.ready;
	assign sts.op_tick     = op_tick;
	assign sts.fired_any   = (k_q != '0);
	assign sts.fire_at_idx = fire_q[idx];
	assign sts.emit_last   = (RES_CNT_W'(e_q + RES_CNT_W'(1)) == k_q);

`ifndef SYNTHESIS
	a_count_matches_busy: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(busy_q)))
		else $error("active count disagrees with busy slots");

	a_fired_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		k_q == RES_CNT_W'($countones(fire_q)))
		else $error("fired count disagrees with fire mask");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.emit) |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten while held");

	a_emit_marked_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> fire_q[idx])
		else $error("emit from a slot that did not fire");
`endif
endmodule

/* hw/rtl/dtt_ctrl.sv */
// ----------------------------------------------------------------------------
// dtt_ctrl: controller of the deadline timer table
// Sequences accept, slot scan, commit and the fired-timer emit walk.
// ----------------------------------------------------------------------------
module dtt_ctrl import dtt_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  dtt_sts_t                      sts,
	output dtt_cmd_t                      cmd,
	output logic [idx_w(NUM_TIMERS)-1:0]  idx
);
	localparam int IDX_W = idx_w(NUM_TIMERS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SCAN      = 3'd1;
	localparam logic [2:0] S_DRAIN     = 3'd2;
	localparam logic [2:0] S_COMMIT    = 3'd3;
	localparam logic [2:0] S_EMIT_RD   = 3'd4;
	localparam logic [2:0] S_EMIT_WAIT = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		idx_d     = idx_q;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_d = S_DRAIN;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.op_tick && sts.fired_any) begin
					idx_d   = '0;
					state_d = S_EMIT_RD;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_EMIT_RD: begin
				if (sts.fire_at_idx) begin
					state_d = S_EMIT_WAIT;
				end else if (idx_q == IDX_LAST) begin
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_EMIT_WAIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign idx = idx_q;

`ifndef SYNTHESIS
	a_wait_on_fired_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_WAIT) |-> sts.fire_at_idx)
		else $error("emit wait on a slot that did not fire");

	a_drain_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |=> (state_q == S_COMMIT))
		else $error("compare drain not followed by commit");

	a_emit_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT_RD) || (state_q == S_EMIT_WAIT)) |-> (sts.op_tick && sts.fired_any))
		else $error("emit walk without fired timers");
`endif
endmodule

/* tb/sv/dtt_timer_checker.sv */
// ----------------------------------------------------------------------------
// dtt_timer_checker: result checker of the deadline timer table
// Watches the request and result channels, keeps its own copy of the timer
// table, works out the results of each accepted request and compares every
// accepted result word, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module dtt_timer_checker import dtt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dtt_in_if    req,
	dtt_out_if   rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                id_valid;
		logic [ID_W-1:0]     result_id;
		logic [TIME_W-1:0]   fire_time;
		logic [ACNT_W-1:0]   active_count;
		logic                last;
	} timer_result_t;

	logic              slot_used [NUM_TIMERS_DEF];
	logic [ID_W-1:0]   slot_id   [NUM_TIMERS_DEF];
	logic [TIME_W-1:0] slot_due  [NUM_TIMERS_DEF];
	timer_result_t     owed_results[$];
	int                err_count = 0;

	assign errors  = err_count;
	assign pending = owed_results.size();

	function automatic logic [ACNT_W-1:0] timers_active();
		int n;
		n = 0;
		for (int i = 0; i < NUM_TIMERS_DEF; i++)
			if (slot_used[i])
				n++;
		return (n > 31) ? ACNT_W'(31) : ACNT_W'(n);
	endfunction

	function automatic int slot_of(input logic [ID_W-1:0] id);
		for (int i = 0; i < NUM_TIMERS_DEF; i++)
			if (slot_used[i] && slot_id[i] == id)
				return i;
		return -1;
	endfunction

	task automatic run_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] stamp, input logic [LIM_W-1:0] lim);
		int            s;
		int            cap;
		timer_result_t r;
		timer_result_t fired[$];
		cap = (lim > MAX_RESULTS) ? MAX_RESULTS : int'(lim);
		r = '0;
		r.status = ST_OK;
		r.last = 1'b1;
		case (op)
			OP_CREATE: begin
				s = slot_of(id);
				if (s < 0)
					for (int i = NUM_TIMERS_DEF - 1; i >= 0; i--)
						if (!slot_used[i])
							s = i;
				if (s < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_used[s] = 1'b1;
					slot_id[s] = id;
					slot_due[s] = stamp;
				end
				r.active_count = timers_active();
				owed_results.push_back(r);
			end
			OP_CANCEL: begin
				s = slot_of(id);
				if (s < 0)
					r.status = ST_NOT_FOUND;
				else
					slot_used[s] = 1'b0;
				r.active_count = timers_active();
				owed_results.push_back(r);
			end
			OP_GET: begin
				s = slot_of(id);
				if (s < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.id_valid = 1'b1;
					r.result_id = slot_id[s];
					r.fire_time = slot_due[s];
				end
				r.active_count = timers_active();
				owed_results.push_back(r);
			end
			default: begin
				for (int i = 0; i < NUM_TIMERS_DEF && fired.size() < cap; i++)
					if (slot_used[i] && slot_due[i] <= stamp) begin
						r = '0;
						r.status = ST_OK;
						r.id_valid = 1'b1;
						r.result_id = slot_id[i];
						fired.push_back(r);
						slot_used[i] = 1'b0;
					end
				if (fired.size() == 0) begin
					r = '0;
					r.status = ST_OK;
					r.last = 1'b1;
					fired.push_back(r);
				end
				fired[fired.size() - 1].last = 1'b1;
				foreach (fired[j]) begin
					fired[j].active_count = timers_active();
					owed_results.push_back(fired[j]);
				end
			end
		endcase
	endtask

	task automatic field_check(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			err_count++;
			$display("%t %s mismatch: expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_word(input timer_result_t got);
		timer_result_t want;
		if (owed_results.size() == 0) begin
			err_count++;
			$display("%t result word with none owed: expected nothing actual %p", $time, got);
			return;
		end
		want = owed_results.pop_front();
		field_check("status", want.status, got.status);
		field_check("id_valid", want.id_valid, got.id_valid);
		field_check("result_id", want.result_id, got.result_id);
		field_check("fire_time", want.fire_time, got.fire_time);
		field_check("active_count", want.active_count, got.active_count);
		field_check("last", want.last, got.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
				slot_used[i] = 1'b0;
				slot_id[i] = '0;
				slot_due[i] = '0;
			end
			owed_results.delete();
		end else begin
			if (rsp.valid && rsp.ready)
				check_word({rsp.status, rsp.id_valid, rsp.result_id, rsp.fire_time,
					rsp.active_count, rsp.last});
			if (req.valid && req.ready)
				run_request(req.opcode, req.timer_key, req.time_ms, req.fire_cap);
		end
	end

endmodule

/* tb/sv/tb_deadline_timer_table_core.sv */
// ----------------------------------------------------------------------------
// tb_deadline_timer_table_core: testbench of the deadline timer table
// Drives a directed sequence (empty table, missing ids, extreme ids and times,
// fire time update, full table, zero and oversized fire limits, a tick that
// fires every timer) and then random requests over a small id pool and an
// advancing clock, with random gaps on both channels and one long stall of
// the result channel. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_deadline_timer_table_core import dtt_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	bit   hold_req = 1'b0;
	int   errors;
	int   pending;

	dtt_in_if  req ();
	dtt_out_if rsp ();

	deadline_timer_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	dtt_timer_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#3000000;
		$display("tb_deadline_timer_table_core: errors");
		$finish;
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] stamp, input logic [LIM_W-1:0] lim);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.opcode    <= op;
		req.timer_key <= id;
		req.time_ms   <= stamp;
		req.fire_cap  <= lim;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	initial begin
		rsp.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				rsp.ready <= 1'b0;
				for (int c = 0; c < 300; c++)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 19) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [ID_W-1:0]   id_pool [24];
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] now_ms;
		logic [LIM_W-1:0]  lim;
		logic [OP_W-1:0]   op;
		int                pick;
		req.valid     = 1'b0;
		req.opcode    = OP_CREATE;
		req.timer_key = '0;
		req.time_ms   = '0;
		req.fire_cap  = '0;
		foreach (id_pool[i])
			id_pool[i] = $urandom;
		id_pool[0] = '0;
		id_pool[1] = '1;
		now_ms = 48'd1000;
		wait (arst_n);
		@(posedge clk);

		send_word(OP_TICK, '0, '0, LIM_W'(16));
		send_word(OP_GET, 32'd5, '0, '0);
		send_word(OP_CANCEL, 32'd5, '0, '0);
		send_word(OP_CREATE, '0, '1, '0);
		send_word(OP_CREATE, '1, '0, '1);
		send_word(OP_CREATE, '1, 48'd100, '0);
		send_word(OP_GET, '1, '0, '0);
		send_word(OP_GET, '0, '0, '0);
		for (int i = 1; i <= 14; i++)
			send_word(OP_CREATE, ID_W'(i), TIME_W'(i * 10), '0);
		send_word(OP_CREATE, 32'd99, 48'd5, '0);
		send_word(OP_TICK, '0, 48'd1000, '0);
		send_word(OP_TICK, '0, '1, '1);

		for (int n = 0; n < 350; n++) begin
			if (n == 120)
				hold_req = 1'b1;
			if (n == 300)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			id = ($urandom_range(0, 4) != 0) ? id_pool[$urandom_range(0, 23)] : $urandom;
			lim = ($urandom_range(0, 2) != 0) ? LIM_W'($urandom_range(1, 16))
				: LIM_W'($urandom_range(0, 31));
			stamp = {16'($urandom), 32'($urandom)};
			if (pick < 40) begin
				op = OP_CREATE;
				if ($urandom_range(0, 9) != 0)
					stamp = now_ms + TIME_W'($urandom_range(0, 300));
			end else if (pick < 55) begin
				op = OP_CANCEL;
			end else if (pick < 75) begin
				op = OP_GET;
			end else begin
				op = OP_TICK;
				now_ms = now_ms + TIME_W'($urandom_range(0, 120));
				if ($urandom_range(0, 19) != 0)
					stamp = now_ms;
			end
			send_word(op, id, stamp, lim);
		end
		req.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("tb_deadline_timer_table_core: clean");
		else
			$display("tb_deadline_timer_table_core: errors");
		$finish;
	end

endmodule
